// ===== hw/rtl/pvd_pkg.sv =====
package pvd_pkg;

    // DAC resolution; the float code sits at mid scale
    localparam int DAC_BITS = 12;
    localparam logic [DAC_BITS-1:0] FLOAT_CODE = DAC_BITS'(1) << (DAC_BITS - 1);

    // Drive limit in whole codes, loop period divisor, Q.8 scale
    localparam int PID_LIMIT = 2300;
    localparam int DERIV_DIV = 50;
    localparam int FRAC_BITS = 8;
    localparam int T_LIMIT   = PID_LIMIT << FRAC_BITS;

    // Signed width of the mapped code before clamping
    localparam int CODE_W = (DAC_BITS + 1 > 14) ? DAC_BITS + 1 : 14;

    // Configuration port
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BAND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRACT_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTEND_START  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FLOOR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_CEILING  = 3'd7;

    // Cut direction codes
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_RAISE = 2'd0;
    localparam t_dir DIR_LOWER = 2'd1;
    localparam t_dir DIR_OTHER = 2'd2;
    localparam t_dir DIR_NONE  = 2'd3;

endpackage

// ===== hw/rtl/pid_valve_drive.sv =====
// Grade control loop: one control tick in, one valve drive code out.
//
// Input channel (i_valid / o_stall) carries direction, auto state and cut
// distance; output channel (o_valid / i_stall) carries the DAC code and the
// engaged flag. A transfer happens on a rising edge with valid high and stall
// low. Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data by the user, only while the block is idle; the block does not check.
//
// One tick is worked at a time. An engaged tick runs the P, I and D products
// as shift-add multiplies, the divide by the loop time as a restoring divider
// at one quotient bit per cycle, then sums, scales, and maps onto the valve
// range with a shift-add multiply and a restoring divide before the result
// is handed to the output register. A new tick is taken only once the block
// is back in idle. A tick that does not engage the loop goes straight to the
// hand-off to the output register.
//
// Reset (synchronous, active low) loads the register defaults, clears the
// integrator and the stored error and empties the output register. While the
// receiver stalls, the finished result holds in the output register and the
// block waits with o_stall high before loading the next one.
module pid_valve_drive (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [pvd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pvd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // control tick in
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_direction,
    input  logic [7:0]                      i_auto_state,
    input  logic [7:0]                      i_cut_distance,
    // drive code out
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [pvd_pkg::DAC_BITS-1:0]    o_dac_code,
    output logic                            o_engaged
);
    import pvd_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL     = 4'd1;  // P, I, D products
    localparam logic [3:0] S_INT     = 4'd2;  // integrator update, divider load
    localparam logic [3:0] S_DIV_D   = 4'd3;  // D product / loop time
    localparam logic [3:0] S_SUM1    = 4'd4;  // P + I
    localparam logic [3:0] S_SUM2    = 4'd5;  // + D, saturate
    localparam logic [3:0] S_SCALE   = 4'd6;  // drop fraction, pick slope
    localparam logic [3:0] S_MAP_MUL = 4'd7;  // drive * slope
    localparam logic [3:0] S_MAP_LD  = 4'd8;  // divider load
    localparam logic [3:0] S_MAP_DIV = 4'd9;  // / drive limit
    localparam logic [3:0] S_CODE    = 4'd10; // offset, clamp, band
    localparam logic [3:0] S_DONE    = 4'd11; // hand to output register

    localparam int T_W = 34;
    localparam logic [T_W-1:0] T_HI = T_W'(T_LIMIT);
    localparam logic [T_W-1:0] T_LO = T_W'(-T_LIMIT);
    localparam logic [12:0]    DVSR_D   = 13'(DERIV_DIV);
    localparam logic [12:0]    DVSR_MAP = 13'(PID_LIMIT);

    // Configuration registers
    logic [15:0] r_gain_p;
    logic [15:0] r_gain_i;
    logic [23:0] r_gain_d;
    logic [7:0]  r_band;
    logic [11:0] r_ret_start;
    logic [11:0] r_ext_start;
    logic [11:0] r_floor;
    logic [11:0] r_ceil;

    // Loop state
    logic [31:0] r_integ;
    logic [8:0]  r_last_err;

    // Sequencer and datapath
    logic [3:0]  r_state;
    logic [3:0]  n_state;
    logic [4:0]  r_cnt;
    t_dir        r_dir;
    logic        r_e_neg;
    logic        r_de_neg;
    logic        r_band_in;
    logic        r_m_neg;
    logic [8:0]  r_sh_a;
    logic [11:0] r_sh_b;
    logic [23:0] r_mcand;
    logic [23:0] r_acc_p;
    logic [23:0] r_acc_i;
    logic [32:0] r_acc_d;
    logic [11:0] r_rem;
    logic [27:0] r_quo;
    logic [T_W-1:0] r_t;
    logic [DAC_BITS-1:0] r_res_code;
    logic        r_res_eng;

    // Output register
    logic                r_o_valid;
    logic [DAC_BITS-1:0] r_o_code;
    logic                r_o_eng;

    logic w_take;
    logic w_engage;
    logic w_out_free;
    logic w_last;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_dac_code = r_o_code;
    assign o_engaged  = r_o_eng;

    assign w_take     = i_valid && (r_state == S_IDLE);
    assign w_engage   = (i_auto_state == 8'd1) && (i_direction != DIR_NONE);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_last     = (r_cnt == 5'd0);

    // Error and error step at the input transfer
    logic [8:0] w_e;
    logic [9:0] w_de;
    logic [9:0] w_de_abs;
    assign w_e      = (i_direction == DIR_RAISE) ? {1'b0, i_cut_distance}
                                                 : (~{1'b0, i_cut_distance} + 9'd1);
    assign w_de     = {w_e[8], w_e} - {r_last_err[8], r_last_err};
    assign w_de_abs = w_de[9] ? (~w_de + 10'd1) : w_de;

    // Integrator update with saturation to the 32-bit signed range
    logic [24:0] w_inc;
    logic [32:0] w_isum;
    logic [31:0] w_isat;
    assign w_inc  = r_e_neg ? (~{1'b0, r_acc_i} + 25'd1) : {1'b0, r_acc_i};
    assign w_isum = {r_integ[31], r_integ} + {{8{w_inc[24]}}, w_inc};
    assign w_isat = (w_isum[32] != w_isum[31])
                  ? (w_isum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                  : w_isum[31:0];

    // Term sum and saturation at the drive limit
    logic [24:0]    w_p;
    logic [28:0]    w_d;
    logic [T_W-1:0] w_sum1;
    logic [T_W-1:0] w_sum2;
    logic [T_W-1:0] w_tsat;
    assign w_p    = r_e_neg ? (~{1'b0, r_acc_p} + 25'd1) : {1'b0, r_acc_p};
    assign w_d    = r_de_neg ? (~{1'b0, r_quo} + 29'd1) : {1'b0, r_quo};
    assign w_sum1 = {{9{w_p[24]}}, w_p} + {{2{r_integ[31]}}, r_integ};
    assign w_sum2 = r_t + {{5{w_d[28]}}, w_d};
    assign w_tsat = ($signed(w_sum2) > $signed(T_HI)) ? T_HI
                  : (($signed(w_sum2) < $signed(T_LO)) ? T_LO : w_sum2);

    // Whole drive magnitude and slope of the selected side
    logic [T_W-1:0] w_tabs;
    logic [12:0]    w_k;
    logic [12:0]    w_kabs;
    assign w_tabs = r_t[T_W-1] ? (~r_t + T_W'(1)) : r_t;
    assign w_k    = (r_dir == DIR_LOWER) ? ({1'b0, r_floor} - {1'b0, r_ret_start})
                                         : ({1'b0, r_ceil} - {1'b0, r_ext_start});
    assign w_kabs = w_k[12] ? (~w_k + 13'd1) : w_k;

    // Restoring divider step, one quotient bit per cycle
    logic [12:0] w_trial;
    logic [12:0] w_dvsr;
    logic [12:0] w_diff;
    logic        w_ge;
    assign w_dvsr  = (r_state == S_DIV_D) ? DVSR_D : DVSR_MAP;
    assign w_trial = {r_rem, r_acc_d[32]};
    assign w_ge    = (w_trial >= w_dvsr);
    assign w_diff  = w_trial - w_dvsr;

    // Shift-add multiply step, multiplier taken MSB first
    logic [32:0] w_acc_d_step;
    assign w_acc_d_step = {r_acc_d[31:0], 1'b0} + (r_sh_b[11] ? {9'b0, r_mcand} : 33'd0);

    // Offset, clamp and band test
    logic [CODE_W-1:0] w_base;
    logic [CODE_W-1:0] w_mag;
    logic [CODE_W-1:0] w_code;
    logic [CODE_W-1:0] w_ceil_x;
    logic [CODE_W-1:0] w_floor_x;
    logic [CODE_W-1:0] w_c1;
    logic [CODE_W-1:0] w_c2;
    always_comb begin
        w_base    = {{(CODE_W-12){1'b0}},
                     ((r_dir == DIR_LOWER) ? r_ret_start : r_ext_start)};
        w_mag     = {{(CODE_W-12){1'b0}}, r_quo[11:0]};
        w_ceil_x  = {{(CODE_W-12){1'b0}}, r_ceil};
        w_floor_x = {{(CODE_W-12){1'b0}}, r_floor};
        if (r_dir == DIR_OTHER) begin
            w_code = {{(CODE_W-DAC_BITS){1'b0}}, FLOAT_CODE};
        end else if (r_m_neg) begin
            w_code = w_base - w_mag;
        end else begin
            w_code = w_base + w_mag;
        end
        w_c1 = ($signed(w_code) >= $signed(w_ceil_x)) ? w_ceil_x : w_code;
        w_c2 = ($signed(w_c1) <= $signed(w_floor_x)) ? w_floor_x : w_c1;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = w_engage ? S_MUL : S_DONE;
                end
            end
            S_MUL:     if (w_last) n_state = S_INT;
            S_INT:     n_state = S_DIV_D;
            S_DIV_D:   if (w_last) n_state = S_SUM1;
            S_SUM1:    n_state = S_SUM2;
            S_SUM2:    n_state = S_SCALE;
            S_SCALE:   n_state = S_MAP_MUL;
            S_MAP_MUL: if (w_last) n_state = S_MAP_LD;
            S_MAP_LD:  n_state = S_MAP_DIV;
            S_MAP_DIV: if (w_last) n_state = S_CODE;
            S_CODE:    n_state = S_DONE;
            S_DONE:    if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_gain_p    <= 16'd11520;
            r_gain_i    <= 16'd5;
            r_gain_d    <= 24'd793600;
            r_band      <= 8'd2;
            r_ret_start <= 12'd1845;
            r_ext_start <= 12'd2250;
            r_floor     <= 12'd450;
            r_ceil      <= 12'd3645;
            r_integ     <= 32'd0;
            r_last_err  <= 9'd0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAIN_P:        r_gain_p    <= i_cfg_data[15:0];
                    CFG_GAIN_I:        r_gain_i    <= i_cfg_data[15:0];
                    CFG_GAIN_D:        r_gain_d    <= i_cfg_data[23:0];
                    CFG_ERROR_BAND:    r_band      <= i_cfg_data[7:0];
                    CFG_RETRACT_START: r_ret_start <= i_cfg_data[11:0];
                    CFG_EXTEND_START:  r_ext_start <= i_cfg_data[11:0];
                    CFG_CODE_FLOOR:    r_floor     <= i_cfg_data[11:0];
                    CFG_CODE_CEILING:  r_ceil      <= i_cfg_data[11:0];
                    default: ;
                endcase
            end

            // the stored error follows every engaged tick
            if (w_take && w_engage) begin
                r_last_err <= w_e;
            end

            // integrate inside the band, drop the sum outside it
            if (r_state == S_INT) begin
                r_integ <= r_band_in ? w_isat : 32'd0;
            end

            // load the output register when free, drop valid once taken
            if (r_state == S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dir      <= i_direction;
                r_e_neg    <= w_e[8];
                r_de_neg   <= w_de[9];
                r_band_in  <= (i_cut_distance < r_band);
                r_sh_a     <= {1'b0, i_cut_distance};
                r_sh_b     <= {w_de_abs[8:0], 3'b000};
                r_mcand    <= r_gain_d;
                r_acc_p    <= 24'd0;
                r_acc_i    <= 24'd0;
                r_acc_d    <= 33'd0;
                r_cnt      <= 5'd8;
                r_res_code <= FLOAT_CODE;
                r_res_eng  <= 1'b0;
            end
            S_MUL: begin
                r_acc_p <= {r_acc_p[22:0], 1'b0} + (r_sh_a[8] ? {8'b0, r_gain_p} : 24'd0);
                r_acc_i <= {r_acc_i[22:0], 1'b0} + (r_sh_a[8] ? {8'b0, r_gain_i} : 24'd0);
                r_acc_d <= w_acc_d_step;
                r_sh_a  <= {r_sh_a[7:0], 1'b0};
                r_sh_b  <= {r_sh_b[10:0], 1'b0};
                r_cnt   <= r_cnt - 5'd1;
            end
            S_INT: begin
                // top five bits already sit below the divisor
                r_rem   <= {7'b0, r_acc_d[32:28]};
                r_acc_d <= {r_acc_d[27:0], 5'b0};
                r_quo   <= 28'd0;
                r_cnt   <= 5'd27;
            end
            S_DIV_D, S_MAP_DIV: begin
                r_rem   <= w_ge ? w_diff[11:0] : w_trial[11:0];
                r_quo   <= {r_quo[26:0], w_ge};
                r_acc_d <= {r_acc_d[31:0], 1'b0};
                r_cnt   <= r_cnt - 5'd1;
            end
            S_SUM1: begin
                r_t <= w_sum1;
            end
            S_SUM2: begin
                r_t <= w_tsat;
            end
            S_SCALE: begin
                // magnitude shift truncates toward zero
                r_sh_b  <= w_tabs[19:8];
                r_mcand <= {12'b0, w_kabs[11:0]};
                r_m_neg <= r_t[T_W-1] ^ w_k[12] ^ (r_dir == DIR_LOWER);
                r_acc_d <= 33'd0;
                r_cnt   <= 5'd11;
            end
            S_MAP_MUL: begin
                r_acc_d <= w_acc_d_step;
                r_sh_b  <= {r_sh_b[10:0], 1'b0};
                r_cnt   <= r_cnt - 5'd1;
            end
            S_MAP_LD: begin
                // quotient fits 12 bits, so the upper half starts below the limit
                r_rem   <= r_acc_d[23:12];
                r_acc_d <= {r_acc_d[11:0], 21'b0};
                r_quo   <= 28'd0;
                r_cnt   <= 5'd11;
            end
            S_CODE: begin
                r_res_code <= r_band_in ? FLOAT_CODE : DAC_BITS'(w_c2[11:0]);
                r_res_eng  <= 1'b1;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_o_code <= r_res_code;
                    r_o_eng  <= r_res_eng;
                end
            end
            default: ;
        endcase
    end

endmodule
